// ===== sv/length_prefixed_frame_receiver_assert.svh =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver_assert.svh
// Assertion macros used by the frame receiver RTL.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_ASSERT_SVH

// Check that cond implies expr in the same cycle, outside reset.
`define LPFR_ASSERT_SAME(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (cond) |-> (expr)) else $error(msg);

// Check that cond implies expr in the next cycle, outside reset.
`define LPFR_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (cond) |=> (expr)) else $error(msg);

`endif

// ===== sv/lpfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfr_pkg
// Types and constants of the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpfr_pkg;

    localparam logic [7:0]  CH_SOH        = 8'h01;
    localparam logic [7:0]  CH_STX        = 8'h02;
    localparam logic [7:0]  CH_ETX        = 8'h03;
    localparam int unsigned HDR_BYTES     = 5;
    localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_STX     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_ETX     = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE = 3'd0,
        ERR_SOH  = 3'd1,
        ERR_LEN  = 3'd2,
        ERR_STX  = 3'd3,
        ERR_ETX  = 3'd4
    } t_err;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       frame_done;
        t_err       error_code;
    } t_result;

endpackage

// ===== sv/lpfr_step.sv =====
// ----------------------------------------------------------------------------
// lpfr_step
// Next-state and result logic for one received byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpfr_step #(
    parameter int LENGTH_BITS = 16
) (
    input  lpfr_pkg::t_phase         i_phase,
    input  logic [7:0]               i_length_high,
    input  logic [LENGTH_BITS-1:0]   i_remaining,
    input  logic [15:0]              i_max_len,
    input  logic [7:0]               i_byte,
    output lpfr_pkg::t_phase         o_phase,
    output logic [7:0]               o_length_high,
    output logic [LENGTH_BITS-1:0]   o_remaining,
    output lpfr_pkg::t_result        o_result
);

    localparam logic [LENGTH_BITS-1:0] HDR_L = LENGTH_BITS'(lpfr_pkg::HDR_BYTES);

    logic [15:0]              w_raw;
    logic [LENGTH_BITS-1:0]   w_total;
    logic [LENGTH_BITS-1:0]   w_dec;
    logic                     w_len_bad;

    // Assemble the big-endian length and fit it to the counter width.
    assign w_raw     = {i_length_high, i_byte};
    assign w_total   = LENGTH_BITS'(w_raw);
    assign w_len_bad = (w_total < HDR_L) || (33'(w_total) > 33'(i_max_len));
    assign w_dec     = (i_remaining != '0) ? (i_remaining - LENGTH_BITS'(1)) : i_remaining;

    always_comb begin
        o_phase       = i_phase;
        o_length_high = i_length_high;
        o_remaining   = i_remaining;
        o_result      = '{payload_byte: 8'h00, payload_valid: 1'b0,
                          frame_done: 1'b0, error_code: lpfr_pkg::ERR_NONE};
        unique case (i_phase)
            lpfr_pkg::PH_LEN_HI: begin
                o_length_high = i_byte;
                o_phase       = lpfr_pkg::PH_LEN_LO;
            end
            lpfr_pkg::PH_LEN_LO: begin
                if (w_len_bad) begin
                    o_result.error_code = lpfr_pkg::ERR_LEN;
                    o_phase             = lpfr_pkg::PH_HUNT;
                end else begin
                    o_remaining = w_total - HDR_L;
                    o_phase     = lpfr_pkg::PH_STX;
                end
            end
            lpfr_pkg::PH_STX: begin
                if (i_byte != lpfr_pkg::CH_STX) begin
                    o_result.error_code = lpfr_pkg::ERR_STX;
                    o_phase             = lpfr_pkg::PH_HUNT;
                end else if (i_remaining == '0) begin
                    o_phase = lpfr_pkg::PH_ETX;
                end else begin
                    o_phase = lpfr_pkg::PH_PAYLOAD;
                end
            end
            lpfr_pkg::PH_PAYLOAD: begin
                o_result.payload_byte  = i_byte;
                o_result.payload_valid = 1'b1;
                o_remaining            = w_dec;
                if (w_dec == '0) begin
                    o_phase = lpfr_pkg::PH_ETX;
                end
            end
            lpfr_pkg::PH_ETX: begin
                if (i_byte == lpfr_pkg::CH_ETX) begin
                    o_result.frame_done = 1'b1;
                end else begin
                    o_result.error_code = lpfr_pkg::ERR_ETX;
                end
                o_phase = lpfr_pkg::PH_HUNT;
            end
            default: begin
                // Hunt; unused codes fall here too.
                if (i_byte == lpfr_pkg::CH_SOH) begin
                    o_phase = lpfr_pkg::PH_LEN_HI;
                end else begin
                    o_result.error_code = lpfr_pkg::ERR_SOH;
                    o_phase             = lpfr_pkg::PH_HUNT;
                end
            end
        endcase
    end

endmodule

// ===== sv/length_prefixed_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// Deframer for SOH / length / STX / payload / ETX byte streams.
// ----------------------------------------------------------------------------
// The receiver takes one byte per cycle while results are taken and returns
// exactly one result per byte, through an input and a result register.
// Frames are SOH (0x01), a 16-bit big-endian total length that counts the
// payload plus five header bytes, STX (0x02), the payload and ETX (0x03).
// Payload bytes come out with o_payload_valid set, a correct ETX raises
// o_frame_done, and any framing fault gives a nonzero o_error_code (1 bad SOH,
// 2 bad length, 3 bad STX, 4 bad ETX) and restarts the hunt for SOH with the
// next byte. Throughput is one byte per cycle: the byte sits in an input
// register, the phase and length counter are updated as it is processed, and
// the result lands in an output register, so a byte can follow every cycle
// while results are taken. A stalled result holds one more byte in the input
// register and then stalls the input. Write i_cfg_wdata with i_cfg_we to
// set the largest accepted total length (reset 1024); write it only while
// the receiver is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "length_prefixed_frame_receiver_assert.svh"

module length_prefixed_frame_receiver #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // received bytes
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    // results
    output logic        o_pl_valid,
    input  logic        i_pl_stall,
    output logic [7:0]  o_payload_byte,
    output logic        o_payload_valid,
    output logic        o_frame_done,
    output logic [2:0]  o_error_code
);

    // Configuration register
    logic [15:0]              r_max_len;

    // Input register
    logic                     r_in_valid;
    logic [7:0]               r_in_byte;

    // Frame state
    lpfr_pkg::t_phase         r_phase;
    lpfr_pkg::t_phase         n_phase;
    logic [7:0]               r_length_high;
    logic [7:0]               n_length_high;
    logic [LENGTH_BITS-1:0]   r_remaining;
    logic [LENGTH_BITS-1:0]   n_remaining;

    // Result register
    logic                     r_out_valid;
    lpfr_pkg::t_result        r_res;
    lpfr_pkg::t_result        n_res;

    logic                     w_adv;
    logic                     w_proc;
    logic                     w_rx_take;

    // Advance the input stage whenever the result register is free or drains.
    assign w_adv      = !r_out_valid || !i_pl_stall;
    assign w_proc     = r_in_valid && w_adv;
    assign o_rx_stall = r_in_valid && !w_adv;
    assign w_rx_take  = i_rx_valid && !o_rx_stall;

    lpfr_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .i_phase       (r_phase),
        .i_length_high (r_length_high),
        .i_remaining   (r_remaining),
        .i_max_len     (r_max_len),
        .i_byte        (r_in_byte),
        .o_phase       (n_phase),
        .o_length_high (n_length_high),
        .o_remaining   (n_remaining),
        .o_result      (n_res)
    );

    // Hold the largest accepted length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= lpfr_pkg::MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    // Capture a byte transaction; drop the slot once it has been processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_rx_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rx_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Phase register and length bookkeeping: advance once per processed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= lpfr_pkg::PH_HUNT;
            r_length_high <= 8'h00;
            r_remaining   <= '0;
        end else if (w_proc) begin
            r_phase       <= n_phase;
            r_length_high <= n_length_high;
            r_remaining   <= n_remaining;
        end
    end

    // Result register: load a new result whenever the stage advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_res <= n_res;
        end
    end

    assign o_pl_valid      = r_out_valid;
    assign o_payload_byte  = r_res.payload_byte;
    assign o_payload_valid = r_res.payload_valid;
    assign o_frame_done    = r_res.frame_done;
    assign o_error_code    = r_res.error_code;

    // A payload phase always has at least one byte left to come.
    `LPFR_ASSERT_SAME(a_payload_left, i_clk, i_rst_n, r_phase == lpfr_pkg::PH_PAYLOAD, r_remaining != '0, "payload phase with zero bytes left")

    // A payload result never carries completion or an error.
    `LPFR_ASSERT_SAME(a_result_kind, i_clk, i_rst_n, o_pl_valid && o_payload_valid, !o_frame_done && (o_error_code == lpfr_pkg::ERR_NONE), "payload result mixed with done or error")

    // A non-payload result carries a zero payload byte.
    `LPFR_ASSERT_SAME(a_byte_zero, i_clk, i_rst_n, o_pl_valid && !o_payload_valid, o_payload_byte == 8'h00, "payload byte not cleared")

    // Any error or completed frame sends the receiver back to hunting.
    `LPFR_ASSERT_NEXT(a_back_to_hunt, i_clk, i_rst_n, w_proc && (n_res.frame_done || (n_res.error_code != lpfr_pkg::ERR_NONE)), r_phase == lpfr_pkg::PH_HUNT, "no return to hunt after frame end")

endmodule

// ===== sim/length_prefixed_frame_receiver_tb.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver_tb
// Self-checking bench for the SOH / length / STX / payload / ETX deframer.
// ----------------------------------------------------------------------------
// A table of hand-picked bytes comes first. It covers stray bytes while
// hunting, an empty frame, a total length above the limit, SOH where STX
// belongs, the smallest and largest payload bytes, a bad ETX, the largest
// limit with a 0xFFFF length, and a limit below five. A random phase follows
// for each of several limit settings. Most of its stimulus is well-formed
// frames with random payloads, and the rest is line noise, out-of-range
// lengths and corrupted STX or ETX bytes. A deframer model in the bench
// predicts every result that the table does not give, and the bench compares each result that leaves the
// block with the oldest prediction, field by field. Both sides idle in random
// bursts, except in the final phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefixed_frame_receiver_tb;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned BYTES_PER_PHASE = 175;
    localparam int unsigned LIMIT_PHASES = 8;

    // Results that can be read straight off the frame format.
    localparam lpfr_pkg::t_result R_QUIET  = '{8'h00, 1'b0, 1'b0, lpfr_pkg::ERR_NONE};
    localparam lpfr_pkg::t_result R_DONE   = '{8'h00, 1'b0, 1'b1, lpfr_pkg::ERR_NONE};
    localparam lpfr_pkg::t_result R_SOH    = '{8'h00, 1'b0, 1'b0, lpfr_pkg::ERR_SOH};
    localparam lpfr_pkg::t_result R_LEN    = '{8'h00, 1'b0, 1'b0, lpfr_pkg::ERR_LEN};
    localparam lpfr_pkg::t_result R_STX    = '{8'h00, 1'b0, 1'b0, lpfr_pkg::ERR_STX};
    localparam lpfr_pkg::t_result R_ETX    = '{8'h00, 1'b0, 1'b0, lpfr_pkg::ERR_ETX};
    localparam lpfr_pkg::t_result R_PAY_FF = '{8'hFF, 1'b1, 1'b0, lpfr_pkg::ERR_NONE};
    localparam lpfr_pkg::t_result R_PAY_00 = '{8'h00, 1'b1, 1'b0, lpfr_pkg::ERR_NONE};

    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [15:0]       value;   // byte in [7:0], or the new length limit
        bit                typed;   // want holds the known result
        lpfr_pkg::t_result want;
    } t_stim_row;

    // ------------------------------------------------------------------------
    // Signals at the block boundary; every input is known from time zero
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = 16'd0;
    logic        i_rx_valid = 1'b0;
    logic        o_rx_stall;
    logic [7:0]  i_rx_byte = 8'd0;
    logic        o_pl_valid;
    logic        i_pl_stall = 1'b0;
    logic [7:0]  o_payload_byte;
    logic        o_payload_valid;
    logic        o_frame_done;
    logic [2:0]  o_error_code;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    // Idling knobs, set per phase by the stimulus process
    int unsigned stall_pct = 0;
    int unsigned gap_pct = 0;
    bit          quiet_tail = 1'b0;
    int unsigned stall_left = 0;

    // Known result that travels with the byte on the input channel
    bit                row_typed = 1'b0;
    lpfr_pkg::t_result row_want = R_QUIET;

    // Deframer model: phase, first length byte, bytes left, limit
    lpfr_pkg::t_phase  rx_phase;
    logic [7:0]        len_high;
    logic [15:0]       payload_left;
    logic [15:0]       max_len;

    lpfr_pkg::t_result pending_results[$];

    int unsigned mismatches = 0;
    int unsigned bytes_sent = 0;
    int unsigned cfg_writes = 0;
    int unsigned n_payload = 0;
    int unsigned n_done = 0;
    int unsigned n_fault = 0;
    int unsigned quiet_cycles = 0;

    t_stim_row directed_rows [29] = '{
        '{ROW_BYTE, 16'h0000, 1'b1, R_SOH},     // stray zero while hunting
        '{ROW_BYTE, 16'h0001, 1'b0, R_QUIET},   // empty frame: total length 5
        '{ROW_BYTE, 16'h0000, 1'b0, R_QUIET},
        '{ROW_BYTE, 16'h0005, 1'b0, R_QUIET},
        '{ROW_BYTE, 16'h0002, 1'b0, R_QUIET},   // STX straight into ETX check
        '{ROW_BYTE, 16'h0003, 1'b1, R_DONE},
        '{ROW_BYTE, 16'h0001, 1'b0, R_QUIET},   // total 1025, one above reset limit
        '{ROW_BYTE, 16'h0004, 1'b0, R_QUIET},
        '{ROW_BYTE, 16'h0001, 1'b1, R_LEN},     // failing byte is 0x01
        '{ROW_BYTE, 16'h0001, 1'b0, R_QUIET},   // hunt restarts on this byte
        '{ROW_BYTE, 16'h0000, 1'b0, R_QUIET},
        '{ROW_BYTE, 16'h0006, 1'b0, R_QUIET},
        '{ROW_BYTE, 16'h0001, 1'b1, R_STX},     // SOH where STX belongs
        '{ROW_BYTE, 16'h0001, 1'b0, R_QUIET},   // fresh hunt, two payload bytes
        '{ROW_BYTE, 16'h0000, 1'b0, R_QUIET},
        '{ROW_BYTE, 16'h0007, 1'b0, R_QUIET},
        '{ROW_BYTE, 16'h0002, 1'b0, R_QUIET},
        '{ROW_BYTE, 16'h00FF, 1'b1, R_PAY_FF},
        '{ROW_BYTE, 16'h0000, 1'b1, R_PAY_00},
        '{ROW_BYTE, 16'h0001, 1'b1, R_ETX},     // SOH where ETX belongs
        '{ROW_CFG,  16'hFFFF, 1'b0, R_QUIET},   // largest limit
        '{ROW_BYTE, 16'h0001, 1'b0, R_QUIET},
        '{ROW_BYTE, 16'h00FF, 1'b0, R_QUIET},
        '{ROW_BYTE, 16'h00FF, 1'b0, R_QUIET},   // total 0xFFFF is accepted
        '{ROW_BYTE, 16'h0003, 1'b1, R_STX},
        '{ROW_CFG,  16'h0004, 1'b0, R_QUIET},   // limit below header size
        '{ROW_BYTE, 16'h0001, 1'b0, R_QUIET},
        '{ROW_BYTE, 16'h0000, 1'b0, R_QUIET},
        '{ROW_BYTE, 16'h0005, 1'b1, R_LEN}      // even an empty frame fails
    };

    // ------------------------------------------------------------------------
    // Device under test
    // ------------------------------------------------------------------------
    length_prefixed_frame_receiver DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_rx_valid      (i_rx_valid),
        .o_rx_stall      (o_rx_stall),
        .i_rx_byte       (i_rx_byte),
        .o_pl_valid      (o_pl_valid),
        .i_pl_stall      (i_pl_stall),
        .o_payload_byte  (o_payload_byte),
        .o_payload_valid (o_payload_valid),
        .o_frame_done    (o_frame_done),
        .o_error_code    (o_error_code)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Deframer model: advance the phase by one byte and return its result
    // ------------------------------------------------------------------------
    function automatic lpfr_pkg::t_result deframe_step(input logic [7:0] b);
        lpfr_pkg::t_result r;
        logic [15:0]       total;
        r = R_QUIET;
        case (rx_phase)
            lpfr_pkg::PH_LEN_HI: begin
                len_high = b;
                rx_phase = lpfr_pkg::PH_LEN_LO;
            end
            lpfr_pkg::PH_LEN_LO: begin
                total = {len_high, b};
                if (total < lpfr_pkg::HDR_BYTES || total > max_len) begin
                    r.error_code = lpfr_pkg::ERR_LEN;
                    rx_phase = lpfr_pkg::PH_HUNT;
                end else begin
                    payload_left = 16'(total - lpfr_pkg::HDR_BYTES);
                    rx_phase = lpfr_pkg::PH_STX;
                end
            end
            lpfr_pkg::PH_STX: begin
                if (b != lpfr_pkg::CH_STX) begin
                    r.error_code = lpfr_pkg::ERR_STX;
                    rx_phase = lpfr_pkg::PH_HUNT;
                end else begin
                    rx_phase = (payload_left == 16'd0) ? lpfr_pkg::PH_ETX
                                                       : lpfr_pkg::PH_PAYLOAD;
                end
            end
            lpfr_pkg::PH_PAYLOAD: begin
                r.payload_byte = b;
                r.payload_valid = 1'b1;
                if (payload_left != 16'd0)
                    payload_left = payload_left - 16'd1;
                if (payload_left == 16'd0)
                    rx_phase = lpfr_pkg::PH_ETX;
            end
            lpfr_pkg::PH_ETX: begin
                if (b == lpfr_pkg::CH_ETX)
                    r.frame_done = 1'b1;
                else
                    r.error_code = lpfr_pkg::ERR_ETX;
                rx_phase = lpfr_pkg::PH_HUNT;
            end
            default: begin
                // Unreachable phase codes fall back to hunting as well
                if (b == lpfr_pkg::CH_SOH) begin
                    rx_phase = lpfr_pkg::PH_LEN_HI;
                end else begin
                    r.error_code = lpfr_pkg::ERR_SOH;
                    rx_phase = lpfr_pkg::PH_HUNT;
                end
            end
        endcase
        return r;
    endfunction

    // Follow the register and every accepted byte; queue what must come out.
    always @(posedge i_clk) begin
        lpfr_pkg::t_result got;
        lpfr_pkg::t_result exp_res;
        if (!i_rst_n) begin
            rx_phase = lpfr_pkg::PH_HUNT;
            len_high = 8'd0;
            payload_left = 16'd0;
            max_len = lpfr_pkg::MAX_LEN_RESET;
        end else begin
            if (i_cfg_we)
                max_len = i_cfg_wdata;
            if (i_rx_valid && !o_rx_stall) begin
                got = deframe_step(i_rx_byte);
                exp_res = row_typed ? row_want : got;
                pending_results = {pending_results, exp_res};
                n_payload += 32'(got.payload_valid);
                n_done += 32'(got.frame_done);
                n_fault += 32'(got.error_code != lpfr_pkg::ERR_NONE);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        lpfr_pkg::t_result want;
        if (i_rst_n && o_pl_valid && !i_pl_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("payload_byte", want.payload_byte, o_payload_byte);
                check_field("payload_valid", 8'(want.payload_valid),
                            8'(o_payload_valid));
                check_field("frame_done", 8'(want.frame_done), 8'(o_frame_done));
                check_field("error_code", 8'(want.error_code), 8'(o_error_code));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output stall: random bursts, none in the final phase
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left != 0)
            stall_left = stall_left - 1;
        else if (!quiet_tail && $urandom_range(0, 99) < stall_pct)
            stall_left = $urandom_range(1, 15);
        i_pl_stall <= (stall_left != 0);
    end

    // Abort when no transaction of any kind happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_rx_valid && !o_rx_stall) ||
            (o_pl_valid && !i_pl_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("length_prefixed_frame_receiver_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // Offer one byte, maybe after a random gap, and hold it until accepted.
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input lpfr_pkg::t_result want);
        if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
            i_rx_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte <= b;
        row_typed <= typed;
        row_want <= want;
        do @(posedge i_clk); while (o_rx_stall);
        bytes_sent++;
    endtask

    // Drain the block, then write the length limit while it is idle.
    task automatic set_max_len(input logic [15:0] lim);
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= lim;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    // Send one random unit: line noise, a frame with a bad length, or a
    // frame that is clean or carries a corrupted STX or ETX.
    task automatic send_random_frame(input logic [15:0] lim);
        int unsigned pick;
        int unsigned body;
        int unsigned total;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            repeat ($urandom_range(1, 3)) begin
                b = 8'($urandom_range(0, 255));
                send_byte(b, 1'b0, R_QUIET);
            end
        end else begin
            if (pick < 18) begin
                // Out of range: just above the limit, or shorter than the header
                if (lim != 16'hFFFF && $urandom_range(0, 1) == 1)
                    total = lim + 1 + $urandom_range(0, 40);
                else
                    total = $urandom_range(0, lpfr_pkg::HDR_BYTES - 1);
                if (total > 16'hFFFF)
                    total = 16'hFFFF;
            end else begin
                // Mostly short payloads, now and then a long one
                if ($urandom_range(0, 15) == 0)
                    body = $urandom_range(13, 300);
                else
                    body = $urandom_range(0, 12);
                total = body + lpfr_pkg::HDR_BYTES;
                if (lim >= lpfr_pkg::HDR_BYTES && total > lim)
                    total = lim;
            end
            send_byte(lpfr_pkg::CH_SOH, 1'b0, R_QUIET);
            send_byte(total[15:8], 1'b0, R_QUIET);
            send_byte(total[7:0], 1'b0, R_QUIET);
            if (total >= lpfr_pkg::HDR_BYTES && total <= lim) begin
                b = lpfr_pkg::CH_STX;
                if (pick >= 18 && pick < 24) begin
                    do b = 8'($urandom_range(0, 255)); while (b == lpfr_pkg::CH_STX);
                end
                send_byte(b, 1'b0, R_QUIET);
                if (b == lpfr_pkg::CH_STX) begin
                    // Favor control characters inside the payload now and then
                    repeat (total - lpfr_pkg::HDR_BYTES) begin
                        if ($urandom_range(0, 7) == 0)
                            b = 8'($urandom_range(1, 3));
                        else
                            b = 8'($urandom_range(0, 255));
                        send_byte(b, 1'b0, R_QUIET);
                    end
                    b = lpfr_pkg::CH_ETX;
                    if (pick >= 24 && pick < 30) begin
                        do b = 8'($urandom_range(0, 255)); while (b == lpfr_pkg::CH_ETX);
                    end
                    send_byte(b, 1'b0, R_QUIET);
                end
            end
        end
    endtask

    initial begin
        logic [15:0] lim;
        int unsigned target;

        // Hold reset, then release it
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table with moderate idling on both sides
        stall_pct <= 20;
        gap_pct <= 20;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG)
                set_max_len(directed_rows[i].value);
            else
                send_byte(directed_rows[i].value[7:0], directed_rows[i].typed,
                          directed_rows[i].want);
        end

        // One random phase per limit setting; the last runs without idling
        for (int ph = 0; ph < LIMIT_PHASES; ph++) begin
            case (ph)
                0: lim = 16'd64;
                1: lim = 16'hFFFF;
                2: lim = 16'd5;
                3: lim = 16'd0;
                4: lim = 16'($urandom_range(6, 40));
                5: lim = 16'($urandom_range(5, 65535));
                6: lim = lpfr_pkg::MAX_LEN_RESET;
                default: lim = 16'($urandom_range(8, 200));
            endcase
            set_max_len(lim);
            stall_pct <= 15 * $urandom_range(0, 2);
            gap_pct <= 15 * $urandom_range(0, 2);
            quiet_tail <= (ph == LIMIT_PHASES - 1);
            target = bytes_sent + BYTES_PER_PHASE;
            while (bytes_sent < target)
                send_random_frame(lim);
        end

        // Drop valid, drain, then give stray results a chance to show up
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d bytes over %0d limit writes: %0d payload bytes, %0d frames closed,",
                 bytes_sent, cfg_writes, n_payload, n_done);
        $display("%0d framing faults, %0d mismatches", n_fault, mismatches);
        if (mismatches == 0)
            $display("length_prefixed_frame_receiver_tb passed");
        else
            $display("length_prefixed_frame_receiver_tb failed");
        $finish;
    end

endmodule
